/* design/histogram_inverse_cdf_sampler_top_macros.svh */
// Assertion macros for the histogram inverse CDF sampler.
`ifndef HISTOGRAM_INVERSE_CDF_SAMPLER_TOP_MACROS_SVH
`define HISTOGRAM_INVERSE_CDF_SAMPLER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HICS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define HICS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hics_pkg.sv */
// Shared constants and types for the histogram inverse CDF sampler.
`default_nettype none
package hics_pkg;

  localparam int MAX_KNOTS_DEF  = 4096;
  localparam int EDGE_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 32;

  localparam int FUNC_W  = 1;
  localparam int INDEX_W = 12;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 13;
  localparam int STEP_W  = 5;

  localparam logic [CFG_W-1:0] KNOTS_USED_RESET = 13'd2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b1;

  // shift unit opcodes
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_HOLD     = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_MUL = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL      = 3'd2;
  localparam logic [OP_W-1:0] OP_LOAD_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV      = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } hics_cmd_t;

endpackage
`default_nettype wire

/* design/hics_ifs.sv */
// Request channel interfaces: sample/load input, result output, config write.
`default_nettype none
interface hics_in_if;
  import hics_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [INDEX_W-1:0]       knot_index;
  logic signed [VAL_W-1:0]  knot_edge;
  logic [VAL_W-1:0]         knot_count;
  logic [VAL_W-1:0]         uniform_value;
  modport source (output valid, func, knot_index, knot_edge, knot_count, uniform_value,
                  input ready);
  modport sink   (input valid, func, knot_index, knot_edge, knot_count, uniform_value,
                  output ready);
endinterface

interface hics_out_if;
  import hics_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  sample_value;
  logic                     miss;
  modport source (output valid, sample_value, miss, input ready);
  modport sink   (input valid, sample_value, miss, output ready);
endinterface

interface hics_cfg_if;
  import hics_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_W-1:0]  knots_used;
  modport source (output valid, knots_used, input ready);
  modport sink   (input valid, knots_used, output ready);
endinterface
`default_nettype wire

/* design/hics_knot_mem.sv */
// Knot table: one write port, one registered read port, word = {edge, count}.
`default_nettype none
module hics_knot_mem #(
  parameter int DEPTH = hics_pkg::MAX_KNOTS_DEF,
  parameter int WIDTH = hics_pkg::EDGE_BITS_DEF + hics_pkg::COUNT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire logic [WIDTH-1:0]          wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
  output      logic [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* design/hics_shift_unit.sv */
// Shared shift-add / shift-subtract unit: serial multiply and restoring divide.
`default_nettype none
module hics_shift_unit #(
  parameter int AW  = 65,
  parameter int OPW = 33,
  parameter int CB  = hics_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire hics_pkg::hics_cmd_t           cmd,
  input  wire logic [AW-1:0]                 ld_acc,
  input  wire logic [OPW-1:0]                ld_opnd,
  input  wire logic [hics_pkg::VAL_W-1:0]    ld_mq,
  output      logic [AW-1:0]                 acc,
  output      logic [hics_pkg::VAL_W-1:0]    mq
);
  import hics_pkg::*;

  logic [AW-1:0]    acc_r, acc_nxt;
  logic [OPW-1:0]   opnd_r, opnd_nxt;
  logic [VAL_W-1:0] mq_r, mq_nxt;

  logic [AW-1:0]    add_x, add_y;
  logic             add_cin;
  logic [AW:0]      add_s;
  logic [CB:0]      div_t;
  logic [CB-1:0]    rem_nxt;
  logic             ge;

  // remainder sits above the 32 dividend bits still to be shifted in
  assign div_t = {acc_r[VAL_W +: CB], acc_r[VAL_W-1]};

  always_comb begin
    add_x   = {acc_r[AW-2:0], 1'b0};
    add_y   = mq_r[VAL_W-1] ? AW'(opnd_r) : '0;
    add_cin = 1'b0;
    if (cmd.op == OP_DIV) begin
      add_x   = AW'(div_t);
      add_y   = ~AW'(opnd_r[CB-1:0]);
      add_cin = 1'b1;
    end
  end

  assign add_s   = {1'b0, add_x} + {1'b0, add_y} + (AW+1)'(add_cin);
  assign ge      = add_s[AW];
  assign rem_nxt = ge ? add_s[CB-1:0] : div_t[CB-1:0];

  always_comb begin
    acc_nxt  = acc_r;
    opnd_nxt = opnd_r;
    mq_nxt   = mq_r;
    unique case (cmd.op)
      OP_LOAD_MUL: begin
        acc_nxt  = '0;
        opnd_nxt = ld_opnd;
        mq_nxt   = ld_mq;
      end
      OP_MUL: begin
        acc_nxt = add_s[AW-1:0];
        mq_nxt  = {mq_r[VAL_W-2:0], 1'b0};
      end
      OP_LOAD_DIV: begin
        acc_nxt  = ld_acc;
        opnd_nxt = ld_opnd;
        mq_nxt   = '0;
      end
      OP_DIV: begin
        acc_nxt = AW'({rem_nxt, acc_r[VAL_W-2:0], 1'b0});
        mq_nxt  = {mq_r[VAL_W-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    opnd_r <= opnd_nxt;
    mq_r   <= mq_nxt;
  end

  assign acc = acc_r;
  assign mq  = mq_r;

endmodule
`default_nettype wire

/* design/histogram_inverse_cdf_sampler_top.sv */
// Top level of the histogram inverse CDF sampler: sequencer, knot table, shift unit.
//
//   channel | dir | request payload
//   --------+-----+----------------------------------------------------------
//   in_ch   | in  | func, knot_index, knot_edge, knot_count, uniform_value
//   out_ch  | out | sample_value, miss (one per sample request)
//   cfg_ch  | in  | knots_used
//
// Load request: writes one knot if its index is in range; the sequencer stays idle. Sample:
// a linear scan finds the bin k (1 to n-1, n = knots_used held to 2..MAX_KNOTS), one knot
// table read a cycle, among the 96 serial steps of the shared shift unit (multiply, then
// after the scan divide and multiply). A miss skips the divide and the second multiply.
// Reset clears control state only; the knot table has no clearing pass.
// A finished result waits in the output register; loads keep flowing meanwhile,
// and a following sample holds in its last step until the output is free.
`default_nettype none
`include "histogram_inverse_cdf_sampler_top_macros.svh"
module histogram_inverse_cdf_sampler_top #(
  parameter int MAX_KNOTS  = hics_pkg::MAX_KNOTS_DEF,
  parameter int EDGE_BITS  = hics_pkg::EDGE_BITS_DEF,
  parameter int COUNT_BITS = hics_pkg::COUNT_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  hics_in_if.sink   in_ch,
  hics_out_if.source out_ch,
  hics_cfg_if.sink  cfg_ch
);
  import hics_pkg::*;

  localparam int EB  = EDGE_BITS;
  localparam int CB  = COUNT_BITS;
  localparam int AWD = $clog2(MAX_KNOTS);
  localparam int PW  = VAL_W + CB;
  localparam int QW  = VAL_W + EB + 1;
  localparam int AW  = (PW > QW) ? PW : QW;
  localparam int OPW = (CB > EB + 1) ? CB : EB + 1;
  localparam int EW  = (EB > VAL_W) ? EB : VAL_W;
  localparam int CW  = (CB > VAL_W) ? CB : VAL_W;
  localparam int RW  = (EB + 1 > VAL_W) ? EB + 1 : VAL_W;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] ST_TLOAD  = 4'd1;
  localparam logic [ST_W-1:0] ST_MUL1   = 4'd2;
  localparam logic [ST_W-1:0] ST_SCAN0  = 4'd3;
  localparam logic [ST_W-1:0] ST_SCAN   = 4'd4;
  localparam logic [ST_W-1:0] ST_DIVLD  = 4'd5;
  localparam logic [ST_W-1:0] ST_DIV    = 4'd6;
  localparam logic [ST_W-1:0] ST_MUL2LD = 4'd7;
  localparam logic [ST_W-1:0] ST_MUL2   = 4'd8;
  localparam logic [ST_W-1:0] ST_FIN    = 4'd9;

  logic [ST_W-1:0]   state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [CFG_W-1:0]  knots_used_r;
  logic [VAL_W-1:0]  u_r, u_nxt;
  logic [AWD-1:0]    last_r, last_nxt;
  logic [AWD-1:0]    ai_r, ai_nxt;
  logic [CB-1:0]     prev_c_r, prev_c_nxt, cur_c_r, cur_c_nxt;
  logic [EB-1:0]     prev_e_r, prev_e_nxt, cur_e_r, cur_e_nxt;
  logic [EB:0]       w_r, w_nxt;
  logic              miss_r, miss_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic              out_miss_r, out_miss_nxt;

  logic              in_fire, load_fire, sample_fire;
  logic              wr_en;
  logic [AWD-1:0]    wr_addr, rd_addr, n_last;
  logic [EW-1:0]     edge_ext;
  logic [CW-1:0]     cnt_ext;
  logic [EB+CB-1:0]  rd_word;
  logic [EB-1:0]     rd_edge;
  logic [CB-1:0]     rd_count;
  logic [31:0]       kn, n_int;

  hics_cmd_t         cmd;
  logic [AW-1:0]     ld_acc, acc;
  logic [OPW-1:0]    ld_opnd;
  logic [VAL_W-1:0]  ld_mq, mq;
  logic [CB-1:0]     ph;
  logic              hit, out_free;
  logic [EB:0]       mag, delta, e0x, res;
  logic signed [RW-1:0] res_ext;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign load_fire    = in_fire && (in_ch.func == FUNC_LOAD);
  assign sample_fire  = in_fire && (in_ch.func == FUNC_SAMPLE);

  // knot writes; edges sign-extend or truncate, counts zero-extend or truncate
  assign edge_ext = EW'(in_ch.knot_edge);
  assign cnt_ext  = CW'(in_ch.knot_count);
  assign wr_en    = load_fire && (32'(in_ch.knot_index) < 32'(MAX_KNOTS));
  assign wr_addr  = AWD'(in_ch.knot_index);

  always_comb begin
    kn = 32'(knots_used_r);
    priority if (kn < 32'd2) begin
      n_int = 32'd2;
    end else if (kn > 32'(MAX_KNOTS)) begin
      n_int = 32'(MAX_KNOTS);
    end else begin
      n_int = kn;
    end
  end
  assign n_last = AWD'(n_int - 32'd1);

  always_comb begin
    unique case (state_r)
      ST_IDLE:  rd_addr = n_last;
      ST_SCAN0: rd_addr = AWD'(1);
      ST_SCAN:  rd_addr = ai_r + AWD'(1);
      default:  rd_addr = '0;
    endcase
  end

  hics_knot_mem #(
    .DEPTH (MAX_KNOTS),
    .WIDTH (EB + CB)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({edge_ext[EB-1:0], cnt_ext[CB-1:0]}),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_edge  = rd_word[CB +: EB];
  assign rd_count = rd_word[CB-1:0];

  // integer part of the scaled fraction decides the bin
  assign ph  = acc[VAL_W +: CB];
  assign hit = (prev_c_r <= ph) && (ph < rd_count);

  assign mag   = w_r[EB] ? (~w_r + 1'b1) : w_r;
  assign delta = acc[VAL_W +: EB+1];
  assign e0x   = {prev_e_r[EB-1], prev_e_r};
  assign res   = w_r[EB] ? (e0x - delta) : (e0x + delta);
  assign res_ext = RW'(signed'(res));

  always_comb begin
    unique case (state_r)
      ST_TLOAD:  cmd.op = OP_LOAD_MUL;
      ST_MUL1:   cmd.op = OP_MUL;
      ST_DIVLD:  cmd.op = OP_LOAD_DIV;
      ST_DIV:    cmd.op = OP_DIV;
      ST_MUL2LD: cmd.op = OP_LOAD_MUL;
      ST_MUL2:   cmd.op = OP_MUL;
      default:   cmd.op = OP_HOLD;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_TLOAD: ld_opnd = OPW'(rd_count);
      ST_DIVLD: ld_opnd = OPW'(cur_c_r - prev_c_r);
      default:  ld_opnd = OPW'(mag);
    endcase
  end
  assign ld_mq  = (state_r == ST_TLOAD) ? u_r : mq;
  assign ld_acc = AW'({CB'(ph - prev_c_r), acc[VAL_W-1:0]});

  hics_shift_unit #(
    .AW  (AW),
    .OPW (OPW),
    .CB  (CB)
  ) u_unit (
    .clk     (clk),
    .cmd     (cmd),
    .ld_acc  (ld_acc),
    .ld_opnd (ld_opnd),
    .ld_mq   (ld_mq),
    .acc     (acc),
    .mq      (mq)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    u_nxt         = u_r;
    last_nxt      = last_r;
    ai_nxt        = ai_r;
    prev_c_nxt    = prev_c_r;
    prev_e_nxt    = prev_e_r;
    cur_c_nxt     = cur_c_r;
    cur_e_nxt     = cur_e_r;
    w_nxt         = w_r;
    miss_nxt      = miss_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_miss_nxt  = out_miss_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sample_fire) begin
          u_nxt     = in_ch.uniform_value;
          last_nxt  = n_last;
          state_nxt = ST_TLOAD;
        end
      end
      ST_TLOAD: begin
        cnt_nxt   = '1;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SCAN0;
        end
      end
      ST_SCAN0: begin
        prev_c_nxt = rd_count;
        prev_e_nxt = rd_edge;
        ai_nxt     = AWD'(1);
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (hit) begin
          cur_c_nxt = rd_count;
          cur_e_nxt = rd_edge;
          miss_nxt  = 1'b0;
          state_nxt = ST_DIVLD;
        end else if (ai_r == last_r) begin
          miss_nxt  = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          prev_c_nxt = rd_count;
          prev_e_nxt = rd_edge;
          ai_nxt     = ai_r + AWD'(1);
        end
      end
      ST_DIVLD: begin
        w_nxt     = {cur_e_r[EB-1], cur_e_r} - {prev_e_r[EB-1], prev_e_r};
        cnt_nxt   = '1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_MUL2LD;
        end
      end
      ST_MUL2LD: begin
        cnt_nxt   = '1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_miss_nxt  = miss_r;
          out_value_nxt = miss_r ? '0 : res_ext[VAL_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      knots_used_r <= KNOTS_USED_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        knots_used_r <= cfg_ch.knots_used;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    u_r         <= u_nxt;
    last_r      <= last_nxt;
    ai_r        <= ai_nxt;
    prev_c_r    <= prev_c_nxt;
    prev_e_r    <= prev_e_nxt;
    cur_c_r     <= cur_c_nxt;
    cur_e_r     <= cur_e_nxt;
    w_r         <= w_nxt;
    miss_r      <= miss_nxt;
    out_value_r <= out_value_nxt;
    out_miss_r  <= out_miss_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_value = signed'(out_value_r);
  assign out_ch.miss         = out_miss_r;

  `HICS_ASSERT_NEXT(a_sample_starts, clk, rst_n, sample_fire, state_r == ST_TLOAD, "sample request did not start the multiply")
  `HICS_ASSERT_NEXT(a_load_stays_idle, clk, rst_n, load_fire, state_r == ST_IDLE, "load request left idle")
  `HICS_ASSERT_SAME(a_scan_in_range, clk, rst_n, state_r == ST_SCAN, ai_r <= last_r, "knot scan ran past last knot")
  `HICS_ASSERT_SAME(a_miss_zero, clk, rst_n, out_valid_r && out_miss_r, out_value_r == '0, "miss result carries nonzero value")

endmodule
`default_nettype wire
